// ===== design/kli_pkg.sv =====
package kli_pkg;
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_SAVE = 2'd2;
    localparam logic [1:0] ACT_PLAY = 2'd3;
    localparam int STEP_BITS = 10;
    localparam logic [STEP_BITS-1:0] STEP_COUNT_RESET = 10'd190;
    localparam int CH_BITS = 4;
    localparam int OUT_BITS = 32;
endpackage

// ===== design/kli_div.sv =====
module kli_div import kli_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [VALUE_BITS:0]   i_num,
    input  logic [STEP_BITS-1:0]         i_den,
    output logic                         o_done,
    output logic signed [VALUE_BITS-1:0] o_quo
);
    // restoring division on magnitude, one quotient bit per cycle
    localparam int NB = VALUE_BITS + 1;
    localparam int CB = $clog2(NB + 1);
    localparam logic signed [NB:0] QMAX = {3'b000, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [NB:0] QMIN = {3'b111, {(VALUE_BITS-1){1'b0}}};

    logic [NB-1:0]        r_q, n_q;
    logic [STEP_BITS-1:0] r_rem, n_rem;
    logic [STEP_BITS-1:0] r_den;
    logic                 r_neg;
    logic [CB-1:0]        r_cnt;
    logic                 r_busy, r_done;
    logic [STEP_BITS:0]   shifted;
    logic signed [NB:0]   sq;

    always_comb begin
        shifted = {r_rem, r_q[NB-1]};
        n_q = {r_q[NB-2:0], 1'b0};
        n_rem = shifted[STEP_BITS-1:0];
        if (shifted >= {1'b0, r_den}) begin
            n_rem = STEP_BITS'(shifted - {1'b0, r_den});
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CB'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num[NB-1] ? NB'(-i_num) : NB'(i_num);
            r_neg <= i_num[NB-1];
            r_rem <= '0;
            r_den <= (i_den == '0) ? STEP_BITS'(1) : i_den;
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        sq = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        if (sq > QMAX) o_quo = QMAX[VALUE_BITS-1:0];
        else if (sq < QMIN) o_quo = QMIN[VALUE_BITS-1:0];
        else o_quo = sq[VALUE_BITS-1:0];
    end
    assign o_done = r_done;
endmodule

// ===== design/keyframe_linear_interpolator.sv =====
// Twelve-channel keyframe player. After reset the block clears its current values, one
// channel per cycle, and stalls its input meanwhile. Set, save and play items are taken
// one at a time: a save walks all channels, a play and every segment change compute one
// increment per channel on a serial divider. A tick reads each channel from the value
// memory, updates and writes it back while playing, and emits one result per channel,
// passing a read state and an emit state per channel; the emit waits while the output
// is stalled. Results go out through an output register.
module keyframe_linear_interpolator import kli_pkg::*; #(
    parameter int MAX_KEYFRAMES = 9,
    parameter int CHANNELS = 12,
    parameter int VALUE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [STEP_BITS-1:0] i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [CH_BITS-1:0]   i_channel,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CH_BITS-1:0]   o_out_channel,
    output logic signed [31:0]   o_out_value,
    output logic                 o_playing,
    output logic                 o_last
);
    localparam int CB = $clog2(CHANNELS + 1);
    localparam int KB = $clog2(MAX_KEYFRAMES + 1);
    localparam int KD = MAX_KEYFRAMES * CHANNELS;
    localparam int AB = $clog2(KD);
    localparam logic signed [VALUE_BITS:0] VMAX = {2'b00, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS:0] VMIN = {2'b11, {(VALUE_BITS-1){1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0, S_SET = 4'd1, S_SAVE = 4'd2, S_TICK = 4'd3,
        S_TWAIT = 4'd4, S_DRD = 4'd5, S_DRD2 = 4'd6, S_DST = 4'd7, S_DWT = 4'd8,
        S_TEMIT = 4'd9, S_CLR = 4'd10;

    logic signed [VALUE_BITS-1:0] cur_mem [CHANNELS];
    logic signed [VALUE_BITS-1:0] inc_mem [CHANNELS];
    logic signed [VALUE_BITS-1:0] kf_mem [KD];
    logic signed [VALUE_BITS-1:0] r_cur_rd, r_inc_rd, r_kf_rd, r_kf_a;

    logic [STEP_BITS-1:0] r_steps;
    logic [3:0]           r_state;
    logic [CB-1:0]        r_ch;
    logic [KB-1:0]        r_kcnt;
    logic [KB-1:0]        r_seg;
    logic [STEP_BITS-1:0] r_stepc;
    logic                 r_play, r_load, r_adv;
    logic [CH_BITS-1:0]   r_ich;
    logic signed [31:0]   r_ival;
    logic                 r_ovalid;
    logic [CH_BITS-1:0]   r_och;
    logic signed [31:0]   r_oval;
    logic                 r_oplay, r_olast;

    logic                 div_start, div_done;
    logic signed [VALUE_BITS-1:0] div_q;
    logic signed [VALUE_BITS:0]   diff, sum;
    logic signed [VALUE_BITS-1:0] sat_sum, sat_set;
    logic [STEP_BITS-1:0] eff;
    logic [AB-1:0]        kf_base;
    logic                 out_free;
    logic [CB-1:0]        ch_rd;

    assign eff = (r_steps == '0) ? STEP_BITS'(1) : r_steps;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign kf_base = AB'(r_seg * CHANNELS);
    assign ch_rd = r_ch;

    always_comb begin
        // in S_DST r_kf_rd holds this keyframe, r_kf_a the next
        diff = $signed({r_kf_a[VALUE_BITS-1], r_kf_a}) - $signed({r_kf_rd[VALUE_BITS-1], r_kf_rd});
        sum = $signed({r_cur_rd[VALUE_BITS-1], r_cur_rd})
            + $signed({r_inc_rd[VALUE_BITS-1], r_inc_rd});
        if (sum > VMAX) sat_sum = VMAX[VALUE_BITS-1:0];
        else if (sum < VMIN) sat_sum = VMIN[VALUE_BITS-1:0];
        else sat_sum = sum[VALUE_BITS-1:0];
        sat_set = VALUE_BITS'(r_ival);
        if (VALUE_BITS < 32) begin
            if ($signed({{(VALUE_BITS+1){r_ival[31]}}, r_ival}) > $signed(VMAX))
                sat_set = VMAX[VALUE_BITS-1:0];
            else if ($signed({{(VALUE_BITS+1){r_ival[31]}}, r_ival}) < $signed(VMIN))
                sat_set = VMIN[VALUE_BITS-1:0];
        end
    end

    kli_div #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(diff), .i_den(eff), .o_done(div_done), .o_quo(div_q)
    );
    assign div_start = (r_state == S_DST);

    // memories: registered reads, address from channel counter
    always_ff @(posedge i_clk) begin
        r_cur_rd <= cur_mem[ch_rd[$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0]];
        r_inc_rd <= inc_mem[ch_rd[$clog2(CHANNELS > 1 ? CHANNELS : 2)-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_steps <= STEP_COUNT_RESET;
            r_kcnt <= '0;
            r_seg <= '0;
            r_stepc <= '0;
            r_play <= 1'b0;
            r_ovalid <= 1'b0;
            r_ch <= '0;
            r_load <= 1'b0;
            r_adv <= 1'b0;
        end else begin
            if (i_cfg_we) r_steps <= i_cfg_wdata;
            if (r_ovalid && !i_stall && r_state != S_TEMIT) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    if (r_ch == CB'(CHANNELS - 1)) begin
                        r_ch <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_ch <= '0;
                    if (i_valid) begin
                        r_ich <= i_channel;
                        r_ival <= i_value;
                        case (i_action)
                            ACT_SET: r_state <= S_SET;
                            ACT_SAVE: begin
                                if (r_kcnt < KB'(MAX_KEYFRAMES)) r_state <= S_SAVE;
                            end
                            ACT_PLAY: begin
                                if (!r_play && r_kcnt > KB'(1)) begin
                                    r_seg <= '0;
                                    r_stepc <= '0;
                                    r_load <= 1'b1;
                                    r_state <= S_DRD;
                                end else begin
                                    r_play <= 1'b0;
                                end
                            end
                            default: begin
                                if (r_play && r_stepc >= eff) begin
                                    if (r_kcnt < KB'(2) || r_seg + 1'b1 > r_kcnt - KB'(2)) begin
                                        r_seg <= '0;
                                        r_play <= 1'b0;
                                        r_adv <= 1'b0;
                                        r_state <= S_TICK;
                                    end else begin
                                        r_seg <= r_seg + 1'b1;
                                        r_stepc <= '0;
                                        r_load <= 1'b0;
                                        r_adv <= 1'b1;
                                        r_state <= S_DRD;
                                    end
                                end else begin
                                    r_adv <= 1'b0;
                                    r_state <= S_TICK;
                                end
                            end
                        endcase
                    end
                end
                S_SET: begin
                    r_state <= S_IDLE;
                end
                S_SAVE: begin
                    // r_cur_rd holds channel r_ch-1 after the first cycle
                    if (r_ch == CB'(CHANNELS)) begin
                        r_kcnt <= r_kcnt + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_DRD: begin
                    r_state <= S_DRD2;
                end
                S_DRD2: begin
                    r_state <= S_DST;
                end
                S_DST: begin
                    r_state <= S_DWT;
                end
                S_DWT: begin
                    if (div_done) begin
                        if (r_ch == CB'(CHANNELS - 1)) begin
                            r_ch <= '0;
                            if (r_load) begin
                                r_play <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_TICK;
                            end
                        end else begin
                            r_ch <= r_ch + 1'b1;
                            r_state <= S_DRD;
                        end
                    end
                end
                S_TICK: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    r_state <= S_TEMIT;
                end
                S_TEMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_och <= CH_BITS'(r_ch);
                        r_oplay <= r_play;
                        r_olast <= (r_ch == CB'(CHANNELS - 1));
                        if (r_play && !r_adv) r_oval <= 32'(sat_sum);
                        else r_oval <= 32'(r_cur_rd);
                        if (r_ch == CB'(CHANNELS - 1)) begin
                            r_ch <= '0;
                            if (r_play && !r_adv) r_stepc <= r_stepc + 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_ch <= r_ch + 1'b1;
                            r_state <= S_TWAIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // write ports of the memories
    logic                         cur_we, inc_we, kf_we;
    logic [CH_BITS-1:0]           cur_wa, inc_wa;
    logic signed [VALUE_BITS-1:0] cur_wd;
    logic [AB-1:0]                kf_wa;
    logic [AB-1:0]                kf_ra;

    always_comb begin
        cur_we = 1'b0;
        cur_wa = CH_BITS'(r_ch);
        cur_wd = sat_sum;
        inc_we = (r_state == S_DWT) && div_done;
        inc_wa = CH_BITS'(r_ch);
        kf_we = (r_state == S_SAVE) && (r_ch != '0);
        kf_wa = AB'(r_kcnt * CHANNELS) + AB'(r_ch - 1'b1);
        case (r_state)
            S_CLR: begin
                cur_we = 1'b1;
                cur_wd = '0;
            end
            S_SET: begin
                cur_we = (r_ich < CH_BITS'(CHANNELS));
                cur_wa = r_ich;
                cur_wd = sat_set;
            end
            S_TEMIT: begin
                cur_we = out_free && r_play && !r_adv;
            end
            S_DWT: begin
                // play start loads keyframe 0 into the current values
                cur_we = div_done && r_load;
                cur_wd = r_kf_rd;
            end
            default: ;
        endcase
        // keyframe read: next keyframe in S_DRD, this keyframe in S_DRD2
        if (r_state == S_DRD) kf_ra = kf_base + AB'(CHANNELS) + AB'(r_ch);
        else kf_ra = kf_base + AB'(r_ch);
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) cur_mem[cur_wa] <= cur_wd;
        if (inc_we) inc_mem[inc_wa] <= div_q;
        if (kf_we) kf_mem[kf_wa] <= r_cur_rd;
        r_kf_rd <= kf_mem[kf_ra];
        if (r_state == S_DRD2) r_kf_a <= r_kf_rd;
    end

    assign o_valid = r_ovalid;
    assign o_out_channel = r_och;
    assign o_out_value = r_oval;
    assign o_playing = r_oplay;
    assign o_last = r_olast;
endmodule

// ===== verif/keyframe_linear_interpolator_tb.sv =====
`timescale 1ns / 100ps

module keyframe_linear_interpolator_tb;
    import kli_pkg::*;

    localparam int NCH = 12;
    localparam int NKEY = 9;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]         action;
        logic [CH_BITS-1:0] channel;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [CH_BITS-1:0] chan;
        logic signed [31:0] value;
        logic               playing;
        logic               last;
    } frame_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [STEP_BITS-1:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_action = ACT_TICK;
    logic [CH_BITS-1:0] i_channel = '0;
    logic signed [31:0] i_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [CH_BITS-1:0] o_out_channel;
    logic signed [31:0] o_out_value;
    logic o_playing;
    logic o_last;

    keyframe_linear_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_channel(i_channel), .i_value(i_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_channel(o_out_channel), .o_out_value(o_out_value),
        .o_playing(o_playing), .o_last(o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // player model state
    logic signed [31:0] cur_val [NCH];
    logic signed [31:0] key_val [NKEY][NCH];
    logic signed [31:0] incr [NCH];
    int unsigned key_cnt;
    bit play_on;
    int unsigned seg;
    int unsigned step_ctr;
    logic [STEP_BITS-1:0] steps;

    cmd_t cmd_q[$];
    frame_t frame_q[$];
    int errors = 0;
    bit calm = 1'b0;
    bit hold_send = 1'b0;
    bit acc_seen = 1'b0;
    int idle_cycles = 0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int unsigned eff_steps();
        return (steps == 0) ? 1 : int'(steps);
    endfunction

    function automatic void load_increments();
        longint d;
        if (seg + 1 >= NKEY) return;
        for (int c = 0; c < NCH; c++) begin
            d = longint'(key_val[seg+1][c]) - longint'(key_val[seg][c]);
            incr[c] = clamp32(d / longint'(eff_steps()));
        end
    endfunction

    function automatic void player_reset();
        for (int c = 0; c < NCH; c++) begin
            cur_val[c] = '0;
            incr[c] = '0;
        end
        key_cnt = 0;
        play_on = 0;
        seg = 0;
        step_ctr = 0;
        steps = STEP_COUNT_RESET;
    endfunction

    function automatic void player_apply(cmd_t cm);
        frame_t f;
        case (cm.action)
            ACT_SET: begin
                if (cm.channel < NCH) cur_val[cm.channel] = cm.value;
            end
            ACT_SAVE: begin
                if (key_cnt < NKEY) begin
                    for (int c = 0; c < NCH; c++) key_val[key_cnt][c] = cur_val[c];
                    key_cnt++;
                end
            end
            ACT_PLAY: begin
                if (!play_on && key_cnt > 1) begin
                    for (int c = 0; c < NCH; c++) cur_val[c] = key_val[0][c];
                    seg = 0;
                    load_increments();
                    play_on = 1;
                    step_ctr = 0;
                end else begin
                    play_on = 0;
                end
            end
            default: begin
                if (play_on) begin
                    if (step_ctr >= eff_steps()) begin
                        seg++;
                        if (key_cnt < 2 || seg > key_cnt - 2) begin
                            seg = 0;
                            play_on = 0;
                        end else begin
                            step_ctr = 0;
                            load_increments();
                        end
                    end else begin
                        for (int c = 0; c < NCH; c++)
                            cur_val[c] = clamp32(longint'(cur_val[c]) + longint'(incr[c]));
                        step_ctr = (step_ctr + 1) & 10'h3ff;
                    end
                end
                for (int c = 0; c < NCH; c++) begin
                    f.chan = CH_BITS'(c);
                    f.value = cur_val[c];
                    f.playing = play_on;
                    f.last = (c == NCH - 1);
                    frame_q.push_back(f);
                end
            end
        endcase
    endfunction

    // driver
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !acc_seen) begin
                // hold payload while stalled
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (cmd_q.size() == 0 || hold_send) begin
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 16);
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_action <= cmd_q[0].action;
                i_channel <= cmd_q[0].channel;
                i_value <= cmd_q[0].value;
            end
        end
    end

    // receiver stall bursts
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        frame_t e;
        acc_seen <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (i_valid && !o_stall) begin
                player_apply(cmd_t'{i_action, i_channel, i_value});
                void'(cmd_q.pop_front());
            end
            if (o_valid && !i_stall) begin
                if (frame_q.size() == 0) begin
                    $error("unexpected result channel %0d value %0d", o_out_channel, o_out_value);
                    errors++;
                end else begin
                    e = frame_q.pop_front();
                    if (o_out_channel !== e.chan) begin
                        $error("out_channel expected %0d actual %0d", e.chan, o_out_channel);
                        errors++;
                    end
                    if (o_out_value !== e.value) begin
                        $error("out_value expected %0d actual %0d", e.value, o_out_value);
                        errors++;
                    end
                    if (o_playing !== e.playing) begin
                        $error("playing expected %0d actual %0d", e.playing, o_playing);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, o_last);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 8) - 4;
            default: return $urandom();
        endcase
    endfunction

    task automatic push(logic [1:0] a, logic [CH_BITS-1:0] ch, logic signed [31:0] v);
        cmd_q.push_back(cmd_t'{a, ch, v});
    endtask

    task automatic drain();
        wait (cmd_q.size() == 0 && !i_valid);
        wait (frame_q.size() == 0);
        // a play may still be dividing with nothing expected
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_steps(logic [STEP_BITS-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        steps = v;
    endtask

    // keyframe animation: sets, saves, play, then ticks with occasional random actions
    task automatic anim(int nkeys, int nticks);
        for (int k = 0; k < nkeys; k++) begin
            for (int j = $urandom_range(1, 4); j > 0; j--)
                push(ACT_SET, CH_BITS'($urandom_range(0, NCH - 1)), rand_value());
            push(ACT_SAVE, CH_BITS'($urandom()), $urandom());
        end
        push(ACT_PLAY, CH_BITS'($urandom()), $urandom());
        for (int t = 0; t < nticks; t++) begin
            if ($urandom_range(0, 30) == 0)
                push(2'($urandom_range(0, 3)), CH_BITS'($urandom()), $urandom());
            else push(ACT_TICK, CH_BITS'($urandom()), $urandom());
        end
    endtask

    initial begin
        player_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks, bad channel, play with too few keys, extremes
        push(ACT_TICK, 0, 0);
        push(ACT_SET, 15, 32'sh7fffffff);
        push(ACT_SET, 12, 5);
        push(ACT_PLAY, 0, 0);
        push(ACT_SET, 0, 32'sh7fffffff);
        push(ACT_SET, 11, 32'sh80000000);
        push(ACT_SAVE, 0, 0);
        push(ACT_PLAY, 0, 0);
        push(ACT_SET, 0, 32'sh80000000);
        push(ACT_SET, 11, 32'sh7fffffff);
        push(ACT_SAVE, 0, 0);
        push(ACT_TICK, 0, 0);
        drain();
        write_steps(0);
        push(ACT_PLAY, 0, 0);
        for (int t = 0; t < 4; t++) push(ACT_TICK, 0, 0);
        push(ACT_PLAY, 0, 0);
        push(ACT_TICK, 0, 0);
        drain();
        hold_send = 0;

        write_steps(1023);
        anim(2, 6);
        drain();
        // reset was the only way to clear keyframes, so fill up and check store full
        write_steps(3);
        anim(8, 25);
        drain();
        write_steps(1);
        push(ACT_PLAY, 0, 0);
        for (int t = 0; t < 10; t++) push(ACT_TICK, CH_BITS'($urandom()), $urandom());
        drain();
        write_steps(STEP_BITS'($urandom_range(2, 5)));
        push(ACT_PLAY, 0, 0);
        calm = 1'b1;
        for (int t = 0; t < 15; t++) push($urandom_range(0, 7) == 0 ? ACT_PLAY : ACT_TICK,
                                          CH_BITS'($urandom()), $urandom());
        drain();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== keyframe_linear_interpolator.f =====
design/kli_pkg.sv
design/kli_div.sv
design/keyframe_linear_interpolator.sv
verif/keyframe_linear_interpolator_tb.sv
